/* design/lhtd_pkg.sv */
`default_nettype none

package lhtd_pkg;

  // fixed field widths of the request and response words
  localparam int unsigned REQ_W    = 2;
  localparam int unsigned ELEM_W   = 32;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_FRONT = 2'd0,
    REQ_PUSH_BACK  = 2'd1,
    REQ_DELETE     = 2'd2,
    REQ_READ       = 2'd3
  } lhtd_req_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE    = 2'd0,
    STATUS_BAD_POS = 2'd1,
    STATUS_FULL    = 2'd2
  } lhtd_status_e;

  // command broadcast to every cell of the chain
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_PUSH_FRONT,
    OP_PUSH_BACK,
    OP_DELETE,
    OP_ROTATE
  } lhtd_op_e;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } lhtd_state_e;

endpackage

`default_nettype wire

/* design/lhtd_req_if.sv */
`default_nettype none

interface lhtd_req_if import lhtd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [REQ_W-1:0]         req_type;
  logic signed [ELEM_W-1:0] elem_in;
  logic [POS_W-1:0]         position;

  modport source (output valid, output req_type, output elem_in, output position,
                  input ready);
  modport sink (input valid, input req_type, input elem_in, input position,
                output ready);
endinterface

`default_nettype wire

/* design/lhtd_rsp_if.sv */
`default_nettype none

interface lhtd_rsp_if import lhtd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [ELEM_W-1:0] elem_out;
  logic                     is_last;
  logic                     list_empty;
  logic [STATUS_W-1:0]      status;

  modport source (output valid, output elem_out, output is_last, output list_empty,
                  output status, input ready);
  modport sink (input valid, input elem_out, input is_last, input list_empty,
                input status, output ready);
endinterface

`default_nettype wire

/* design/lhtd_cell.sv */
`default_nettype none

module lhtd_cell import lhtd_pkg::*; #(
  parameter int unsigned IDX = 0,
  parameter int unsigned CW  = 7,
  parameter int unsigned VW  = 32
) (
  input  logic          clk_i,
  input  lhtd_op_e      op_i,
  input  logic [CW-1:0] cnt_i,
  input  logic [CW-1:0] pos_i,
  input  logic [VW-1:0] ins_i,
  input  logic [VW-1:0] left_i,
  input  logic [VW-1:0] right_i,
  input  logic [VW-1:0] head_i,
  output logic [VW-1:0] val_o
);

  logic [VW-1:0] val_q, val_d;

  always_comb begin
    val_d = val_q;
    case (op_i)
      OP_PUSH_FRONT: val_d = left_i;
      OP_PUSH_BACK: begin
        if (CW'(IDX) == cnt_i) begin
          val_d = ins_i;
        end
      end
      OP_DELETE: begin
        if (CW'(IDX) >= pos_i) begin
          val_d = right_i;
        end
      end
      // tail of the occupied part takes the head, so the ring is count long
      OP_ROTATE: val_d = (CW'(IDX) + CW'(1) == cnt_i) ? head_i : right_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

`default_nettype wire

/* design/list_head_tail_insert_indexed_delete.sv */
`default_nettype none

// bounded deque of signed values with delete by position
// request channel req_i: req_type (push front, push back, delete at position,
//   read only), elem_in and position; one word per request
// response channel rsp_o: the whole list front to back after every request,
//   one word per entry, is_last on the final word; an empty list gives a single
//   word with list_empty set and elem_out zero; every word carries the status
// the request is applied in the cycle it is accepted; the first response word
//   shows in the next cycle and then one word per cycle while rsp_o.ready is high
// a request holding n entries afterwards gives max(n,1) words: the read-out
//   rotates the chain of cells by one place per word, and a new request is
//   accepted only after the last word is taken
// a stalled receiver simply freezes the rotation; nothing is lost
// reset empties the list at once; cell contents need no clearing
module list_head_tail_insert_indexed_delete import lhtd_pkg::*; #(
  parameter int unsigned CAPACITY    = 64,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lhtd_req_if.sink   req_i,
  lhtd_rsp_if.source rsp_o
);

  // count width holds CAPACITY itself, index width addresses the cells
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned PW = (CW > POS_W) ? CW : POS_W;

  lhtd_state_e          state_q, state_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [IW-1:0]        idx_q, idx_d;
  lhtd_status_e         status_q, status_d;
  lhtd_op_e             op;
  logic [VALUE_WIDTH-1:0] ins_val;
  logic [CW-1:0]        pos_cell;
  logic                 pos_bad;
  logic                 list_full;
  logic                 req_fire;
  logic                 rsp_fire;
  logic                 at_last;
  logic [VALUE_WIDTH-1:0] cell_val [CAPACITY];

  assign req_fire = req_i.valid && req_i.ready;
  assign rsp_fire = rsp_o.valid && rsp_o.ready;

  // incoming value keeps its low bits, zero padded where cells are wider
  assign ins_val   = VALUE_WIDTH'($unsigned(req_i.elem_in));
  assign pos_cell  = CW'(req_i.position);
  assign pos_bad   = PW'(req_i.position) >= PW'(cnt_q);
  assign list_full = (cnt_q == CW'(CAPACITY));
  assign at_last   = (cnt_q == '0) || (CW'(idx_q) + CW'(1) == cnt_q);

  // command to the chain and bookkeeping of count, read index and status
  always_comb begin
    op       = OP_HOLD;
    cnt_d    = cnt_q;
    idx_d    = idx_q;
    status_d = status_q;
    if (req_fire) begin
      idx_d    = '0;
      status_d = STATUS_DONE;
      case (req_i.req_type)
        REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
          if (list_full) begin
            status_d = STATUS_FULL;
          end else begin
            op    = (req_i.req_type == REQ_PUSH_FRONT) ? OP_PUSH_FRONT : OP_PUSH_BACK;
            cnt_d = cnt_q + CW'(1);
          end
        end
        REQ_DELETE: begin
          if (pos_bad) begin
            status_d = STATUS_BAD_POS;
          end else begin
            op    = OP_DELETE;
            cnt_d = cnt_q - CW'(1);
          end
        end
        default: ;
      endcase
    end else if (rsp_fire && (cnt_q != '0)) begin
      // after count rotations the list is back in order
      op    = OP_ROTATE;
      idx_d = idx_q + IW'(1);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        if (rsp_fire && at_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    req_i.ready = 1'b0;
    rsp_o.valid = 1'b0;
    case (state_q)
      ST_IDLE: req_i.ready = 1'b1;
      ST_READ: rsp_o.valid = 1'b1;
      default: ;
    endcase
  end

  // response word: head cell, sign extended from the cell width, or zero for an empty list
  assign rsp_o.elem_out   = (cnt_q == '0) ? '0 : ELEM_W'($signed(cell_val[0]));
  assign rsp_o.is_last    = at_last;
  assign rsp_o.list_empty = (cnt_q == '0);
  assign rsp_o.status     = status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      idx_q    <= '0;
      status_q <= STATUS_DONE;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      idx_q    <= idx_d;
      status_q <= status_d;
    end
  end

  // chain of cells, cell 0 is the front of the list
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_WIDTH-1:0] left_val;
    logic [VALUE_WIDTH-1:0] right_val;

    if (i == 0) begin : g_front
      assign left_val = ins_val;
    end else begin : g_mid_l
      assign left_val = cell_val[i-1];
    end

    if (i == CAPACITY - 1) begin : g_back
      assign right_val = cell_val[i];
    end else begin : g_mid_r
      assign right_val = cell_val[i+1];
    end

    lhtd_cell #(
      .IDX (i),
      .CW  (CW),
      .VW  (VALUE_WIDTH)
    ) u_cell (
      .clk_i   (clk_i),
      .op_i    (op),
      .cnt_i   (cnt_q),
      .pos_i   (pos_cell),
      .ins_i   (ins_val),
      .left_i  (left_val),
      .right_i (right_val),
      .head_i  (cell_val[0]),
      .val_o   (cell_val[i])
    );
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_req_to_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> rsp_o.valid)
    else $error("no response word after accepted request");

  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.list_empty) |-> rsp_o.is_last)
    else $error("empty list word not marked last");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_READ) && (cnt_q != '0)) |-> (CW'(idx_q) < cnt_q))
    else $error("read index beyond list");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_fire && at_last) |=> req_i.ready)
    else $error("not ready after last word");
`endif

endmodule

`default_nettype wire

/* bench/lhtd_tb_pkg.sv */
`timescale 1ns / 100ps

package lhtd_tb_pkg;
  import lhtd_pkg::*;

  localparam int unsigned LIST_CAP = 64;

  typedef struct {
    logic signed [ELEM_W-1:0] elem;
    logic                     is_last;
    logic                     list_empty;
    lhtd_status_e             status;
  } readout_word_t;

  // shadow copy of the deque plus the read-out words still owed by the block
  class deque_shadow;
    logic signed [ELEM_W-1:0] entries[$];
    readout_word_t            pending_words[$];
    int unsigned              mismatches;

    function new();
      mismatches = 0;
    endfunction

    function int unsigned depth();
      return entries.size();
    endfunction

    function int unsigned pending();
      return pending_words.size();
    endfunction

    // apply one accepted request and queue the read-out that follows it
    function void book_request(lhtd_req_e kind, logic signed [ELEM_W-1:0] value,
                               logic [POS_W-1:0] pos);
      lhtd_status_e  status;
      readout_word_t w;
      status = STATUS_DONE;
      case (kind)
        REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
          if (entries.size() >= LIST_CAP) begin
            status = STATUS_FULL;
          end else if (kind == REQ_PUSH_FRONT) begin
            entries.push_front(value);
          end else begin
            entries.push_back(value);
          end
        end
        REQ_DELETE: begin
          if (int'(pos) >= entries.size()) begin
            status = STATUS_BAD_POS;
          end else begin
            entries.delete(int'(pos));
          end
        end
        default: ;
      endcase
      if (entries.size() == 0) begin
        w.elem       = '0;
        w.is_last    = 1'b1;
        w.list_empty = 1'b1;
        w.status     = status;
        pending_words.push_back(w);
      end else begin
        foreach (entries[i]) begin
          w.elem       = entries[i];
          w.is_last    = (i == entries.size() - 1);
          w.list_empty = 1'b0;
          w.status     = status;
          pending_words.push_back(w);
        end
      end
    endfunction

    function void flag(string field, longint want, longint got);
      mismatches++;
      $display("%0t: read-out %s mismatch, expected %0d, got %0d", $time, field, want, got);
    endfunction

    // compare one accepted read-out word against the oldest one owed
    function void check_word(logic signed [ELEM_W-1:0] elem, logic last, logic empty,
                             logic [STATUS_W-1:0] status);
      readout_word_t w;
      if (pending_words.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected word, expected none, got elem %0d last %b empty %b status %0d",
                 $time, elem, last, empty, status);
        return;
      end
      w = pending_words.pop_front();
      if (elem !== w.elem) flag("elem_out", w.elem, elem);
      if (last !== w.is_last) flag("is_last", w.is_last, last);
      if (empty !== w.list_empty) flag("list_empty", w.list_empty, empty);
      if (status !== w.status) flag("status", w.status, status);
    endfunction
  endclass

endpackage

/* bench/tb_list_head_tail_insert_indexed_delete.sv */
`timescale 1ns / 100ps

module tb_list_head_tail_insert_indexed_delete;
  import lhtd_pkg::*;
  import lhtd_tb_pkg::*;

  localparam int unsigned ITEM_BUDGET  = 430;
  // receiver hold-off long enough to park the block on a full 64-word read-out
  localparam int unsigned HOLD_CYCLES  = 250;
  // cycles without any word moving on either channel before giving up
  localparam int unsigned STALL_LIMIT  = 4000;
  // the first read-out word shows in the cycle after the request, so a short tail is plenty
  localparam int unsigned DRAIN_CYCLES = 20;

  localparam logic signed [ELEM_W-1:0] ELEM_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
  localparam logic signed [ELEM_W-1:0] ELEM_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  lhtd_req_if req_bus ();
  lhtd_rsp_if rsp_bus ();

  deque_shadow shadow;
  int unsigned items_sent  = 0;
  int unsigned burst_left  = 0;
  int unsigned idle_cycles = 0;
  // raised by the sender, served and cleared by the receiver process
  bit          hold_off_req = 1'b0;

  list_head_tail_insert_indexed_delete u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // values lean on the extremes now and then, otherwise fully random bits
  function automatic logic signed [ELEM_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return ELEM_MIN;
      1: return ELEM_MAX;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  // present one request word and hold it until the block takes it
  task automatic send_request(lhtd_req_e kind, logic signed [ELEM_W-1:0] value,
                              logic [POS_W-1:0] pos);
    @(negedge clk_i);
    req_bus.valid    <= 1'b1;
    req_bus.req_type <= kind;
    req_bus.elem_in  <= value;
    req_bus.position <= pos;
    do @(posedge clk_i); while (!req_bus.ready);
    // let the monitor book the word before the next decision reads the shadow list
    #1;
    items_sent++;
  endtask

  // sender works in bursts: a random gap opens each new burst, some bursts are long
  task automatic issue(lhtd_req_e kind, logic signed [ELEM_W-1:0] value,
                       logic [POS_W-1:0] pos);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 50) : $urandom_range(1, 8);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        @(negedge clk_i);
        req_bus.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    send_request(kind, value, pos);
  endtask

  // drop valid and wait until every owed read-out word has been taken
  task automatic drain();
    @(negedge clk_i);
    req_bus.valid <= 1'b0;
    burst_left = 0;
    while (shadow.pending() != 0) @(negedge clk_i);
  endtask

  // mostly inserts until the list is full, then a few more words against the full list
  task automatic grow_phase();
    int unsigned extra;
    extra = $urandom_range(3, 8);
    while (extra != 0) begin
      if (shadow.depth() == LIST_CAP) extra--;
      case ($urandom_range(0, 9))
        0: issue(REQ_DELETE, pick_value(), POS_W'($urandom_range(0, 63)));
        1: issue(REQ_READ, pick_value(), POS_W'($urandom));
        2, 3, 4, 5: issue(REQ_PUSH_FRONT, pick_value(), POS_W'($urandom));
        default: issue(REQ_PUSH_BACK, pick_value(), POS_W'($urandom));
      endcase
    end
  endtask

  // mostly in-range deletes until the list is empty, then a few words on the empty list
  task automatic shrink_phase();
    int unsigned extra;
    extra = $urandom_range(2, 5);
    while (extra != 0) begin
      if (shadow.depth() == 0) extra--;
      case ($urandom_range(0, 9))
        0: issue(lhtd_req_e'($urandom_range(0, 1)), pick_value(), POS_W'($urandom));
        1: issue(REQ_READ, pick_value(), POS_W'($urandom));
        2: issue(REQ_DELETE, pick_value(), POS_W'($urandom_range(0, 63)));
        default: begin
          if (shadow.depth() == 0) begin
            issue(REQ_DELETE, pick_value(), POS_W'($urandom_range(0, 63)));
          end else begin
            issue(REQ_DELETE, pick_value(), POS_W'($urandom_range(0, shadow.depth() - 1)));
          end
        end
      endcase
    end
  endtask

  // unshaped words: any request type, any value, any position
  task automatic noise_phase();
    repeat (30) issue(lhtd_req_e'($urandom_range(0, 3)), $urandom, POS_W'($urandom));
  endtask

  // receiver: segments of steady, random or periodic stalls, plus one long hold-off
  initial begin
    int unsigned mode;
    int unsigned seg;
    int unsigned tick;
    tick = 0;
    rsp_bus.ready = 1'b0;
    wait (rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      seg  = $urandom_range(8, 60);
      repeat (seg) begin
        @(negedge clk_i);
        if (hold_off_req) begin
          rsp_bus.ready <= 1'b0;
          repeat (HOLD_CYCLES) @(negedge clk_i);
          hold_off_req = 1'b0;
        end
        tick++;
        case (mode)
          0: rsp_bus.ready <= 1'b1;
          1: rsp_bus.ready <= 1'($urandom_range(0, 1));
          2: rsp_bus.ready <= (tick % 5) < 3;
          default: rsp_bus.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // monitor: read-out words are checked before a request on the same edge is booked
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        shadow.check_word(rsp_bus.elem_out, rsp_bus.is_last, rsp_bus.list_empty,
                          rsp_bus.status);
      end
      if (req_bus.valid && req_bus.ready) begin
        shadow.book_request(lhtd_req_e'(req_bus.req_type), req_bus.elem_in,
                            req_bus.position);
      end
      if ((rsp_bus.valid && rsp_bus.ready) || (req_bus.valid && req_bus.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
        $display("tb_list_head_tail_insert_indexed_delete failed");
        $finish;
      end
    end
  end

  initial begin
    shadow = new();
    req_bus.valid    = 1'b0;
    req_bus.req_type = REQ_READ;
    req_bus.elem_in  = '0;
    req_bus.position = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty list, extremes at both ends, deletes at front, middle, back and past the end
    issue(REQ_READ, '0, '0);
    issue(REQ_DELETE, '0, 6'd0);
    issue(REQ_PUSH_BACK, ELEM_MAX, 6'd0);
    issue(REQ_PUSH_FRONT, ELEM_MIN, 6'd63);
    issue(REQ_PUSH_BACK, '0, 6'd0);
    issue(REQ_PUSH_FRONT, '1, 6'd0);
    issue(REQ_READ, '1, '1);
    issue(REQ_DELETE, '0, 6'd63);
    issue(REQ_DELETE, '0, 6'd4);
    issue(REQ_DELETE, '0, 6'd3);
    issue(REQ_DELETE, '0, 6'd0);
    issue(REQ_PUSH_BACK, 32'sh5555_5555, 6'd0);
    issue(REQ_PUSH_FRONT, 32'shAAAA_AAAA, 6'd0);
    issue(REQ_DELETE, '0, 6'd1);
    issue(REQ_DELETE, '0, 6'd2);
    issue(REQ_DELETE, '0, 6'd0);
    issue(REQ_DELETE, '0, 6'd0);
    issue(REQ_DELETE, '0, 6'd0);
    issue(REQ_READ, '0, '0);
    issue(REQ_PUSH_FRONT, 32'sd1, 6'd0);
    issue(REQ_PUSH_BACK, 32'sd2, 6'd0);
    issue(REQ_READ, '0, '0);

    // fill the list, then stall the receiver on full read-outs while requests keep coming
    grow_phase();
    hold_off_req = 1'b1;
    shrink_phase();
    // sender goes quiet until the block has handed over everything it owes
    drain();
    noise_phase();
    while (items_sent < ITEM_BUDGET) begin
      grow_phase();
      shrink_phase();
      noise_phase();
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (shadow.mismatches == 0 && shadow.pending() == 0) begin
      $display("tb_list_head_tail_insert_indexed_delete passed");
    end else begin
      $display("tb_list_head_tail_insert_indexed_delete failed");
    end
    $finish;
  end

endmodule
